### sv/bbp_pkg.sv
// ----------------------------------------------------------------------------
// bbp_pkg - shared types and constants for the bearing unit
// word layout passed along the degree cell chain, special case codes and the
// tangent constants for each whole degree
// ----------------------------------------------------------------------------
package bbp_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MAG_W   = COORD_W;
  localparam int HEAD_W  = 9;
  localparam int DEGM_W  = HEAD_W - 1;
  localparam int NUM_DEG = 44;
  localparam int CNT_W   = 6;
  localparam int FRAC_W  = 48;
  localparam int HALF_W  = FRAC_W / 2;
  localparam int PROD_W  = MAG_W + HALF_W;

  localparam logic [DEGM_W-1:0] DEG_ZERO     = 8'd0;
  localparam logic [DEGM_W-1:0] DEG_DIAG     = 8'd45;
  localparam logic [DEGM_W-1:0] DEG_OCT_TOP  = 8'd89;
  localparam logic [DEGM_W-1:0] DEG_RIGHT    = 8'd90;
  localparam logic [DEGM_W-1:0] DEG_BACK_TOP = 8'd179;
  localparam logic [DEGM_W-1:0] DEG_HALF     = 8'd180;

  localparam real PI_R       = 3.14159265358979323846;
  localparam real FRAC_SCALE = 2.0 ** FRAC_W;

  typedef enum logic [2:0] {
    KIND_ZERO,
    KIND_VERT,
    KIND_AXIS,
    KIND_DIAG,
    KIND_OCT
  } bbp_kind_t;

  typedef struct packed {
    bbp_kind_t kind;
    logic      neg_x;
    logic      neg_y;
    logic      swap;
  } bbp_side_t;

  typedef struct packed {
    bbp_side_t          side;
    logic [MAG_W-1:0]   num;
    logic [MAG_W-1:0]   den;
    logic [CNT_W-1:0]   cnt;
    logic               alive;
  } bbp_word_t;

  // tan of a whole degree as an unsigned fraction with FRAC_W bits
  function automatic logic [FRAC_W-1:0] tan_q(input int deg);
    real ang;
    real scaled;
    ang    = real'(deg) * PI_R / 180.0;
    scaled = $tan(ang) * FRAC_SCALE;
    return FRAC_W'(longint'(scaled));
  endfunction

endpackage

### sv/bbp_front.sv
// ----------------------------------------------------------------------------
// bbp_front - difference vector and case split
// forms dx and dy, their magnitudes, sorts them into the octant ratio and
// registers the word that enters the degree cell chain
// ----------------------------------------------------------------------------
module bbp_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [bbp_pkg::COORD_W-1:0] in_from_x,
  input  logic signed [bbp_pkg::COORD_W-1:0] in_from_y,
  input  logic signed [bbp_pkg::COORD_W-1:0] in_to_x,
  input  logic signed [bbp_pkg::COORD_W-1:0] in_to_y,
  output logic                              valid_o,
  output bbp_pkg::bbp_word_t                word_o
);
  import bbp_pkg::*;

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic [DIFF_W-1:0]        ax_full;
  logic [DIFF_W-1:0]        ay_full;
  logic [MAG_W-1:0]         ax;
  logic [MAG_W-1:0]         ay;
  logic                     valid_r;
  bbp_word_t                word_r;
  bbp_word_t                word_nxt;

  assign dx      = DIFF_W'(in_to_x) - DIFF_W'(in_from_x);
  assign dy      = DIFF_W'(in_to_y) - DIFF_W'(in_from_y);
  assign ax_full = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign ay_full = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
  assign ax      = ax_full[MAG_W-1:0];
  assign ay      = ay_full[MAG_W-1:0];

  always_comb begin
    word_nxt.side.neg_x = dx[DIFF_W-1];
    word_nxt.side.neg_y = dy[DIFF_W-1];
    word_nxt.side.swap  = ax > ay;
    word_nxt.cnt        = '0;
    word_nxt.alive      = 1'b1;
    // octant ratio is always smaller over larger
    word_nxt.num        = (ax > ay) ? ay : ax;
    word_nxt.den        = (ax > ay) ? ax : ay;
    if (ax == '0 && ay == '0) begin
      word_nxt.side.kind = KIND_ZERO;
    end else if (ax == '0) begin
      word_nxt.side.kind = KIND_VERT;
    end else if (ay == '0) begin
      word_nxt.side.kind = KIND_AXIS;
    end else if (ax == ay) begin
      word_nxt.side.kind = KIND_DIAG;
    end else begin
      word_nxt.side.kind = KIND_OCT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;

endmodule

### sv/bbp_cell.sv
// ----------------------------------------------------------------------------
// bbp_cell - one whole degree of the octant search
// decides num/den > tan(DEG) exactly with a split constant product over two
// register stages and bumps the running degree count while it holds
// ----------------------------------------------------------------------------
module bbp_cell #(
  parameter int DEG = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  bbp_pkg::bbp_word_t word_i,
  output logic               valid_o,
  output bbp_pkg::bbp_word_t word_o
);
  import bbp_pkg::*;

  localparam logic [FRAC_W-1:0] TAN_Q  = tan_q(DEG);
  localparam logic [HALF_W-1:0] TAN_HI = TAN_Q[FRAC_W-1:HALF_W];
  localparam logic [HALF_W-1:0] TAN_LO = TAN_Q[HALF_W-1:0];

  logic              valid_a_r;
  logic              valid_b_r;
  bbp_word_t         word_a_r;
  bbp_word_t         word_b_r;
  bbp_word_t         word_b_nxt;
  logic [PROD_W-1:0] lo_a_r;
  logic [PROD_W-1:0] lo_a_nxt;
  logic [PROD_W-1:0] hi_prod;
  logic [PROD_W:0]   rhs;
  logic [PROD_W:0]   lhs;
  logic              above;

  // low half of den * tan first, its carry part joins the high half next
  assign lo_a_nxt = PROD_W'(word_i.den) * PROD_W'(TAN_LO);

  assign hi_prod = PROD_W'(word_a_r.den) * PROD_W'(TAN_HI);
  assign rhs     = (PROD_W+1)'(hi_prod) + (PROD_W+1)'(lo_a_r[PROD_W-1:HALF_W]);
  assign lhs     = {1'b0, word_a_r.num, {HALF_W{1'b0}}};
  assign above   = lhs > rhs;

  always_comb begin
    word_b_nxt = word_a_r;
    if (word_a_r.alive && above) begin
      word_b_nxt.cnt = word_a_r.cnt + CNT_W'(1);
    end else begin
      word_b_nxt.alive = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else if (en) begin
      valid_a_r <= valid_i;
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_a_r <= word_i;
      lo_a_r   <= lo_a_nxt;
      word_b_r <= word_b_nxt;
    end
  end

  assign valid_o = valid_b_r;
  assign word_o  = word_b_r;

endmodule

### sv/bbp_back.sv
// ----------------------------------------------------------------------------
// bbp_back - bearing assembly and output register
// turns the degree count and case code into the signed bearing and holds it
// for the consumer, the chain advances whenever this register can move
// ----------------------------------------------------------------------------
module bbp_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              valid_i,
  input  bbp_pkg::bbp_word_t                word_i,
  output logic                              adv,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bbp_pkg::HEAD_W-1:0] out_heading_deg
);
  import bbp_pkg::*;

  logic [DEGM_W-1:0]        u;
  logic [DEGM_W-1:0]        mag;
  logic                     exact;
  logic                     neg;
  logic signed [HEAD_W-1:0] heading_nxt;
  logic signed [HEAD_W-1:0] heading_r;
  logic                     out_valid_r;

  assign adv = !out_valid_r || !out_stall;

  always_comb begin
    u     = DEG_ZERO;
    exact = 1'b0;
    case (word_i.side.kind)
      KIND_AXIS: begin
        u     = DEG_RIGHT;
        exact = 1'b1;
      end
      KIND_DIAG: begin
        u     = DEG_DIAG;
        exact = 1'b1;
      end
      KIND_OCT: begin
        u = word_i.side.swap ? DEG_OCT_TOP - DEGM_W'(word_i.cnt) : DEGM_W'(word_i.cnt);
      end
      default: begin
        u = DEG_ZERO;
      end
    endcase
  end

  always_comb begin
    neg = 1'b0;
    case (word_i.side.kind)
      KIND_ZERO: begin
        mag = DEG_RIGHT;
      end
      KIND_VERT: begin
        mag = word_i.side.neg_y ? DEG_HALF : DEG_ZERO;
      end
      KIND_AXIS, KIND_DIAG, KIND_OCT: begin
        neg = word_i.side.neg_x;
        if (!word_i.side.neg_y) begin
          mag = u;
        end else if (exact) begin
          mag = DEG_HALF - u;
        end else begin
          mag = DEG_BACK_TOP - u;
        end
      end
      default: begin
        mag = DEG_ZERO;
      end
    endcase
    heading_nxt = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      heading_r <= heading_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_heading_deg = heading_r;

endmodule

### sv/bearing_between_points_unit.sv
// pipeline from an accepted point pair to its word on out_valid:
//   1 difference stage, 44 degree cells of 2 stages each, 1 output register
// throughput: one point pair per cycle, the whole chain moves together and
//   holds only while the output register is full and stalled
// reset: synchronous, clears the stage valid bits and the output valid only
// ----------------------------------------------------------------------------
// bearing_between_points_unit - compass bearing between two points
// whole degrees clockwise from +y, truncated toward zero, in -179 to 180
// ----------------------------------------------------------------------------
module bearing_between_points_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [bbp_pkg::COORD_W-1:0] in_from_x,
  input  logic signed [bbp_pkg::COORD_W-1:0] in_from_y,
  input  logic signed [bbp_pkg::COORD_W-1:0] in_to_x,
  input  logic signed [bbp_pkg::COORD_W-1:0] in_to_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bbp_pkg::HEAD_W-1:0] out_heading_deg
);
  import bbp_pkg::*;

  logic      adv;
  logic      chain_valid [NUM_DEG+1];
  bbp_word_t chain_word  [NUM_DEG+1];

  assign in_stall = !adv;

  bbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_valid),
    .in_from_x (in_from_x),
    .in_from_y (in_from_y),
    .in_to_x   (in_to_x),
    .in_to_y   (in_to_y),
    .valid_o   (chain_valid[0]),
    .word_o    (chain_word[0])
  );

  for (genvar g = 0; g < NUM_DEG; g++) begin : g_cell
    bbp_cell #(
      .DEG (g + 1)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (chain_valid[g]),
      .word_i  (chain_word[g]),
      .valid_o (chain_valid[g+1]),
      .word_o  (chain_word[g+1])
    );
  end

  bbp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .valid_i         (chain_valid[NUM_DEG]),
    .word_i          (chain_word[NUM_DEG]),
    .adv             (adv),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_heading_deg (out_heading_deg)
  );

endmodule

### sv/bbp_checker.sv
// ----------------------------------------------------------------------------
// bbp_checker - port level checks for the bearing unit
// output range, back pressure coupling, held words and reset behaviour
// ----------------------------------------------------------------------------
module bbp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [bbp_pkg::HEAD_W-1:0] out_heading_deg
);
  import bbp_pkg::*;

  // bearing word always inside the compass range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_heading_deg) >= -179 && $signed(out_heading_deg) <= 180))
    else $error("bearing out of range");

  // input side stalls exactly when a finished word is held back
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output back pressure");

  // a stalled word stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_heading_deg)))
    else $error("stalled word changed");

  // nothing comes out straight after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind bearing_between_points_unit bbp_checker u_bbp_checker (.*);
